FILE: design/idll_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and defaults for the indexed doubly linked list.
package idll_pkg;

    localparam int DEF_SLOTS       = 16;
    localparam int DEF_RECORD_BITS = 64;

    // a walk gives at most this many words
    localparam int RESULT_LIMIT = 16;
    localparam int WALK_W       = $clog2(RESULT_LIMIT);

    localparam logic [2:0] KIND_ADD_FIRST = 3'd0;
    localparam logic [2:0] KIND_ADD_AFTER = 3'd1;
    localparam logic [2:0] KIND_ADD_LAST  = 3'd2;
    localparam logic [2:0] KIND_DEL_FIRST = 3'd3;
    localparam logic [2:0] KIND_DEL_AFTER = 3'd4;
    localparam logic [2:0] KIND_DEL_LAST  = 3'd5;
    localparam logic [2:0] KIND_CLEAR     = 3'd6;
    localparam logic [2:0] KIND_WALK      = 3'd7;

    localparam logic [2:0] STAT_OK      = 3'd0;
    localparam logic [2:0] STAT_FULL    = 3'd1;
    localparam logic [2:0] STAT_EMPTY   = 3'd2;
    localparam logic [2:0] STAT_BAD_POS = 3'd3;
    localparam logic [2:0] STAT_NO_SUCC = 3'd4;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  position;
        logic [63:0] payload;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  slot;
        logic [63:0] element_data;
        logic [4:0]  count;
        logic        last;
    } out_word_t;

endpackage

FILE: design/idll_link_mem.sv
`timescale 1ns / 1ps
// Link memory: per slot a forward and a backward link, lane write enables.
module idll_link_mem #(
    parameter int SLOTS = 16,
    localparam int IDX_W  = $clog2(SLOTS),
    localparam int LINK_W = $clog2(SLOTS + 1)
) (
    input  logic              aclk,
    input  logic [1:0]        wr_en,     // [1] next lane, [0] prev lane
    input  logic [IDX_W-1:0]  wr_addr,
    input  logic [LINK_W-1:0] wr_next,
    input  logic [LINK_W-1:0] wr_prev,
    input  logic              rd_en,
    input  logic [IDX_W-1:0]  rd_addr,
    output logic [LINK_W-1:0] rd_next,
    output logic [LINK_W-1:0] rd_prev
);

    logic [1:0][LINK_W-1:0] mem [SLOTS];
    logic [1:0][LINK_W-1:0] rd_q_reg;

    always_ff @(posedge aclk) begin
        if (wr_en[1]) begin
            mem[wr_addr][1] <= wr_next;
        end
        if (wr_en[0]) begin
            mem[wr_addr][0] <= wr_prev;
        end
        // read data holds while no read is issued
        if (rd_en) begin
            rd_q_reg <= mem[rd_addr];
        end
    end

    assign rd_next = rd_q_reg[1];
    assign rd_prev = rd_q_reg[0];

endmodule

FILE: design/idll_rec_mem.sv
`timescale 1ns / 1ps
// Record memory: the payload kept in each slot.
module idll_rec_mem #(
    parameter int SLOTS       = 16,
    parameter int RECORD_BITS = 64,
    localparam int IDX_W = $clog2(SLOTS)
) (
    input  logic                   aclk,
    input  logic                   wr_en,
    input  logic [IDX_W-1:0]       wr_addr,
    input  logic [RECORD_BITS-1:0] wr_data,
    input  logic                   rd_en,
    input  logic [IDX_W-1:0]       rd_addr,
    output logic [RECORD_BITS-1:0] rd_data
);

    logic [RECORD_BITS-1:0] mem [SLOTS];
    logic [RECORD_BITS-1:0] rd_q_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_q_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_q_reg;

endmodule

FILE: design/indexed_doubly_linked_list.sv
`timescale 1ns / 1ps
// Top level of the indexed doubly linked list: command sequencer and result register.
// A doubly linked list over SLOTS slots, kept in a link memory (forward and
// backward link per slot) and a record memory, both with one read and one
// write port and a registered read. Head, tail, element count and the in-use
// bits live in flip-flops; a new element takes the lowest free slot. Every
// command except a walk of a non-empty list gives one result word with last
// set. Commands are taken one at a time; s_ready is high only while the
// sequencer is idle, and a finished word may still sit in the output
// register when the next command is taken. Clear and commands that fail a
// check at decode go straight to the result. add_after first reads the
// successor of its position; an add then writes the new slot's links and
// record, the predecessor's forward link or head, and the successor's back
// link or tail (up to three link writes on the single write port). del_first
// and del_last read the victim's links, del_after the successor of its
// position and then its links (STAT_NO_SUCC if none); up to two link writes
// follow. A word still waiting in the output register delays the load until
// m_ready is high. The sequencer is idle again from the edge that loads the
// last word. A walk reads the head slot at decode, then gives one word per
// cycle while m_ready stays high, each next address coming straight from the
// link read of the slot just visited. No clearing pass is needed after reset
// or clear: links of free slots are always rewritten before they are read.
module indexed_doubly_linked_list #(
    parameter int SLOTS       = idll_pkg::DEF_SLOTS,
    parameter int RECORD_BITS = idll_pkg::DEF_RECORD_BITS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  idll_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output idll_pkg::out_word_t m_data
);

    import idll_pkg::*;

    localparam int IDX_W  = $clog2(SLOTS);
    localparam int LINK_W = $clog2(SLOTS + 1);
    // link value meaning "none"; also the count of a full pool
    localparam logic [LINK_W-1:0] NONE_LINK = LINK_W'(SLOTS);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_DECODE = 4'd1;
    localparam logic [3:0] ST_INS_RD = 4'd2;   // add_after: fetch successor of position
    localparam logic [3:0] ST_INS_W1 = 4'd3;   // write links and record of new slot
    localparam logic [3:0] ST_INS_W2 = 4'd4;   // predecessor forward link, or head
    localparam logic [3:0] ST_INS_W3 = 4'd5;   // successor back link, or tail
    localparam logic [3:0] ST_DAF_RD = 4'd6;   // del_after: successor of position
    localparam logic [3:0] ST_DEL_W1 = 4'd7;   // links of victim ready; fix predecessor
    localparam logic [3:0] ST_DEL_W2 = 4'd8;   // fix successor
    localparam logic [3:0] ST_WALK   = 4'd9;
    localparam logic [3:0] ST_RESP   = 4'd10;

    logic [3:0]        state_reg, state_next;
    in_word_t          cmd_reg, cmd_next;
    logic [IDX_W-1:0]  n_reg, n_next;          // slot being allocated
    logic [IDX_W-1:0]  x_reg, x_next;          // slot being freed or visited
    logic [LINK_W-1:0] p_reg, p_next;          // predecessor link
    logic [LINK_W-1:0] q_reg, q_next;          // successor link
    logic [LINK_W-1:0] head_reg, head_next;
    logic [LINK_W-1:0] tail_reg, tail_next;
    logic [LINK_W-1:0] count_reg, count_next;
    logic [SLOTS-1:0]  in_use_reg, in_use_next;
    logic [WALK_W-1:0] walk_k_reg, walk_k_next;
    logic [2:0]        res_status_reg, res_status_next;
    logic [3:0]        res_slot_reg, res_slot_next;
    logic              m_valid_reg, m_valid_next;
    out_word_t         m_data_reg, m_data_next;

    // memory ports
    logic [1:0]             link_wr_en;
    logic [IDX_W-1:0]       link_wr_addr;
    logic [LINK_W-1:0]      link_wr_next;
    logic [LINK_W-1:0]      link_wr_prev;
    logic                   link_rd_en;
    logic [IDX_W-1:0]       link_rd_addr;
    logic [LINK_W-1:0]      rd_next;
    logic [LINK_W-1:0]      rd_prev;
    logic                   rec_wr_en;
    logic                   rec_rd_en;
    logic [IDX_W-1:0]       rec_rd_addr;
    logic [RECORD_BITS-1:0] rec_rd_data;

    logic [IDX_W-1:0]  pos_idx;
    logic              pos_ok;
    logic [IDX_W-1:0]  free_idx;
    logic              full;
    logic              out_free;
    logic              walk_fin;
    logic [LINK_W-1:0] victim;

    idll_link_mem #(
        .SLOTS (SLOTS)
    ) u_link_mem (
        .aclk    (aclk),
        .wr_en   (link_wr_en),
        .wr_addr (link_wr_addr),
        .wr_next (link_wr_next),
        .wr_prev (link_wr_prev),
        .rd_en   (link_rd_en),
        .rd_addr (link_rd_addr),
        .rd_next (rd_next),
        .rd_prev (rd_prev)
    );

    idll_rec_mem #(
        .SLOTS       (SLOTS),
        .RECORD_BITS (RECORD_BITS)
    ) u_rec_mem (
        .aclk    (aclk),
        .wr_en   (rec_wr_en),
        .wr_addr (n_reg),
        .wr_data (cmd_reg.payload[RECORD_BITS-1:0]),
        .rd_en   (rec_rd_en),
        .rd_addr (rec_rd_addr),
        .rd_data (rec_rd_data)
    );

    // position check: must name an existing, occupied slot
    assign pos_idx  = IDX_W'(cmd_reg.position);
    assign pos_ok   = (32'(cmd_reg.position) < 32'(SLOTS)) && in_use_reg[pos_idx];
    assign full     = (count_reg == NONE_LINK);
    assign out_free = !m_valid_reg || m_ready;
    assign walk_fin = (rd_next == NONE_LINK) || (walk_k_reg == WALK_W'(RESULT_LIMIT - 1));
    assign victim   = (cmd_reg.kind == KIND_DEL_FIRST) ? head_reg : tail_reg;

    // lowest free slot
    always_comb begin
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!in_use_reg[i]) begin
                free_idx = IDX_W'(i);
            end
        end
    end

    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        n_next          = n_reg;
        x_next          = x_reg;
        p_next          = p_reg;
        q_next          = q_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        in_use_next     = in_use_reg;
        walk_k_next     = walk_k_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;

        link_wr_en   = 2'b00;
        link_wr_addr = n_reg;
        link_wr_next = q_reg;
        link_wr_prev = p_reg;
        link_rd_en   = 1'b0;
        link_rd_addr = pos_idx;
        rec_wr_en    = 1'b0;
        rec_rd_en    = 1'b0;
        rec_rd_addr  = IDX_W'(head_reg);

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd_next   = s_data;
                    state_next = ST_DECODE;
                end
            end

            ST_DECODE: begin
                res_slot_next = '0;
                unique case (cmd_reg.kind)
                    KIND_ADD_FIRST, KIND_ADD_AFTER, KIND_ADD_LAST: begin
                        n_next = free_idx;
                        // full pool wins over a bad position
                        if (full) begin
                            res_status_next = STAT_FULL;
                            state_next      = ST_RESP;
                        end else if (cmd_reg.kind == KIND_ADD_AFTER && !pos_ok) begin
                            res_status_next = STAT_BAD_POS;
                            state_next      = ST_RESP;
                        end else if (cmd_reg.kind == KIND_ADD_AFTER) begin
                            link_rd_en   = 1'b1;
                            link_rd_addr = pos_idx;
                            p_next       = LINK_W'(pos_idx);
                            state_next   = ST_INS_RD;
                        end else if (cmd_reg.kind == KIND_ADD_LAST && tail_reg != NONE_LINK) begin
                            p_next     = tail_reg;
                            q_next     = NONE_LINK;
                            state_next = ST_INS_W1;
                        end else begin
                            // add_first, or add_last on an empty list
                            p_next     = NONE_LINK;
                            q_next     = head_reg;
                            state_next = ST_INS_W1;
                        end
                    end
                    KIND_DEL_FIRST, KIND_DEL_LAST: begin
                        if (victim == NONE_LINK) begin
                            res_status_next = STAT_EMPTY;
                            state_next      = ST_RESP;
                        end else begin
                            x_next       = IDX_W'(victim);
                            link_rd_en   = 1'b1;
                            link_rd_addr = IDX_W'(victim);
                            state_next   = ST_DEL_W1;
                        end
                    end
                    KIND_DEL_AFTER: begin
                        if (!pos_ok) begin
                            res_status_next = STAT_BAD_POS;
                            state_next      = ST_RESP;
                        end else begin
                            link_rd_en   = 1'b1;
                            link_rd_addr = pos_idx;
                            state_next   = ST_DAF_RD;
                        end
                    end
                    KIND_CLEAR: begin
                        in_use_next     = '0;
                        head_next       = NONE_LINK;
                        tail_next       = NONE_LINK;
                        count_next      = '0;
                        res_status_next = STAT_OK;
                        state_next      = ST_RESP;
                    end
                    KIND_WALK: begin
                        if (head_reg == NONE_LINK) begin
                            res_status_next = STAT_EMPTY;
                            state_next      = ST_RESP;
                        end else begin
                            x_next       = IDX_W'(head_reg);
                            walk_k_next  = '0;
                            link_rd_en   = 1'b1;
                            link_rd_addr = IDX_W'(head_reg);
                            rec_rd_en    = 1'b1;
                            rec_rd_addr  = IDX_W'(head_reg);
                            state_next   = ST_WALK;
                        end
                    end
                    default: state_next = ST_IDLE;
                endcase
            end

            ST_INS_RD: begin
                q_next     = rd_next;
                state_next = ST_INS_W1;
            end

            ST_INS_W1: begin
                link_wr_en   = 2'b11;
                link_wr_addr = n_reg;
                link_wr_next = q_reg;
                link_wr_prev = p_reg;
                rec_wr_en    = 1'b1;
                state_next   = ST_INS_W2;
            end

            ST_INS_W2: begin
                if (p_reg != NONE_LINK) begin
                    link_wr_en   = 2'b10;
                    link_wr_addr = IDX_W'(p_reg);
                    link_wr_next = LINK_W'(n_reg);
                end else begin
                    head_next = LINK_W'(n_reg);
                end
                state_next = ST_INS_W3;
            end

            ST_INS_W3: begin
                if (q_reg != NONE_LINK) begin
                    link_wr_en   = 2'b01;
                    link_wr_addr = IDX_W'(q_reg);
                    link_wr_prev = LINK_W'(n_reg);
                end else begin
                    tail_next = LINK_W'(n_reg);
                end
                in_use_next[n_reg] = 1'b1;
                count_next         = count_reg + LINK_W'(1);
                res_status_next    = STAT_OK;
                res_slot_next      = 4'(n_reg);
                state_next         = ST_RESP;
            end

            ST_DAF_RD: begin
                if (rd_next == NONE_LINK) begin
                    res_status_next = STAT_NO_SUCC;
                    res_slot_next   = '0;
                    state_next      = ST_RESP;
                end else begin
                    x_next       = IDX_W'(rd_next);
                    link_rd_en   = 1'b1;
                    link_rd_addr = IDX_W'(rd_next);
                    state_next   = ST_DEL_W1;
                end
            end

            ST_DEL_W1: begin
                // victim's links are on the read port now
                p_next = rd_prev;
                q_next = rd_next;
                if (rd_prev != NONE_LINK) begin
                    link_wr_en   = 2'b10;
                    link_wr_addr = IDX_W'(rd_prev);
                    link_wr_next = rd_next;
                end else begin
                    head_next = rd_next;
                end
                state_next = ST_DEL_W2;
            end

            ST_DEL_W2: begin
                if (q_reg != NONE_LINK) begin
                    link_wr_en   = 2'b01;
                    link_wr_addr = IDX_W'(q_reg);
                    link_wr_prev = p_reg;
                end else begin
                    tail_next = p_reg;
                end
                in_use_next[x_reg] = 1'b0;
                count_next         = count_reg - LINK_W'(1);
                res_status_next    = STAT_OK;
                res_slot_next      = 4'(x_reg);
                state_next         = ST_RESP;
            end

            ST_WALK: begin
                // read data holds until the word can be loaded
                if (out_free) begin
                    m_valid_next              = 1'b1;
                    m_data_next.status        = STAT_OK;
                    m_data_next.slot          = 4'(x_reg);
                    m_data_next.element_data  = 64'(rec_rd_data);
                    m_data_next.count         = 5'(count_reg);
                    m_data_next.last          = walk_fin;
                    if (walk_fin) begin
                        state_next = ST_IDLE;
                    end else begin
                        x_next       = IDX_W'(rd_next);
                        walk_k_next  = walk_k_reg + WALK_W'(1);
                        link_rd_en   = 1'b1;
                        link_rd_addr = IDX_W'(rd_next);
                        rec_rd_en    = 1'b1;
                        rec_rd_addr  = IDX_W'(rd_next);
                    end
                end
            end

            ST_RESP: begin
                if (out_free) begin
                    m_valid_next             = 1'b1;
                    m_data_next.status       = res_status_reg;
                    m_data_next.slot         = res_slot_reg;
                    m_data_next.element_data = '0;
                    m_data_next.count        = 5'(count_reg);
                    m_data_next.last         = 1'b1;
                    state_next               = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            head_reg    <= NONE_LINK;
            tail_reg    <= NONE_LINK;
            count_reg   <= '0;
            in_use_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            in_use_reg  <= in_use_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        n_reg          <= n_next;
        x_reg          <= x_next;
        p_reg          <= p_next;
        q_reg          <= q_next;
        walk_k_reg     <= walk_k_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        m_data_reg     <= m_data_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef ASSERT_OFF
    // element count tracks the in-use bits
    a_count_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg == LINK_W'($countones(in_use_reg)))
        else $error("element count differs from number of used slots");

    // between commands head and tail agree with the count
    a_ends_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |->
            (((head_reg == NONE_LINK) == (count_reg == '0)) &&
             ((tail_reg == NONE_LINK) == (count_reg == '0))))
        else $error("head or tail disagrees with element count");

    // allocation takes a free slot
    a_alloc_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_INS_W3) |-> !in_use_reg[n_reg])
        else $error("allocated slot already in use");

    // deletion frees a used slot
    a_unlink_used: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DEL_W2) |-> in_use_reg[x_reg])
        else $error("freed slot was not in use");
`endif

endmodule
